/* rtl/e2lc_pkg.sv */
// ----------------------------------------------------------------------------
// e2lc_pkg
// Types, constants and tables shared by the calendar converter modules.
// ----------------------------------------------------------------------------
package e2lc_pkg;

    localparam logic [2:0] CFG_ZONE_OFFSET = 3'd0;
    localparam logic [2:0] CFG_DST_ENABLE  = 3'd1;
    localparam logic [2:0] CFG_DST_SHIFT   = 3'd2;
    localparam logic [2:0] CFG_START_RULE  = 3'd3;
    localparam logic [2:0] CFG_END_RULE    = 3'd4;

    localparam logic [17:0] SEC_PER_DAY   = 18'd86400;
    localparam logic [17:0] SEC_PER_HOUR  = 18'd3600;
    localparam logic [17:0] SEC_PER_MIN   = 18'd60;
    localparam logic [17:0] DAYS_PER_WEEK = 18'd7;
    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [11:0] YEAR_BASE     = 12'd1900;
    localparam logic [2:0]  EPOCH_WDAY    = 3'd4;

    // reciprocals: (x >> 7) / 675 by 2^35, n / 7 by 2^20,
    // (s >> 4) / 225 by 2^21, (s >> 2) / 15 by 2^14
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [17:0] WEEK_RECIP = 18'd149797;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DDAY, S_DDREM, S_DHOUR, S_DHREM, S_DMIN, S_DMREM,
        S_YEAR, S_MON, S_RSTART, S_REND
    } t_state;

    typedef enum logic [2:0] {
        DSEL_DAY, DSEL_DREM, DSEL_HOUR, DSEL_HREM, DSEL_MIN, DSEL_MREM
    } t_dsel;

    typedef struct packed {
        logic  load_in;
        logic  add_shift;
        logic  div_load;
        logic  div_step;
        t_dsel dsel;
        logic  year_init;
        logic  year_step;
        logic  mon_init;
        logic  mon_step;
        logic  rule_init;
        logic  rule_end;
        logic  rule_step;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic mon_done;
        logic rule_done;
        logic dst;
        logic pass;
    } t_sts;

    typedef struct packed {
        logic signed [17:0] zone_offset;
        logic               dst_enable;
        logic signed [17:0] dst_shift;
        logic [17:0]        start_rule;
        logic [17:0]        end_rule;
    } t_cfg;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/epoch_to_local_calendar.sv */
// ----------------------------------------------------------------------------
// epoch_to_local_calendar
// Converts epoch seconds to local broken-down time with daylight rules.
//
// Pulse start for one cycle while busy is low; i_epoch_seconds is taken
// at that edge. busy stays high until the result is shown. o_valid marks
// the result word for one cycle and cannot be held; the o_ ports keep the
// word until the next result. One word in gives one word out; the next
// word can be started in the cycle that shows the result.
// Steps: one load, six divisions by reciprocal multiply, a walk over the
// years since 1970 and one over the months, then the start and end
// daylight rules. When daylight time applies the division, year and month
// steps run a second time.
// Configuration writes on i_cfg_we / i_cfg_idx / i_cfg_data take effect at
// once and are meant for idle periods. Reset restores the register
// defaults, returns the sequencer to idle and clears o_valid.
// ----------------------------------------------------------------------------
module epoch_to_local_calendar (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [17:0]        i_cfg_data,
    input  logic signed [31:0] i_epoch_seconds,
    output logic               o_valid,
    output logic [5:0]         o_second,
    output logic [5:0]         o_minute,
    output logic [4:0]         o_hour,
    output logic [4:0]         o_month_day,
    output logic [3:0]         o_month,
    output logic [7:0]         o_year_since_1900,
    output logic [8:0]         o_year_day,
    output logic [2:0]         o_week_day,
    output logic               o_is_dst
);
    import e2lc_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zone_offset <= 18'sd0;
            r_cfg.dst_enable  <= 1'b0;
            r_cfg.dst_shift   <= 18'sd3600;
            r_cfg.start_rule  <= 18'd17921;
            r_cfg.end_rule    <= 18'd21007;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZONE_OFFSET: r_cfg.zone_offset <= $signed(i_cfg_data);
                CFG_DST_ENABLE:  r_cfg.dst_enable  <= i_cfg_data[0];
                CFG_DST_SHIFT:   r_cfg.dst_shift   <= $signed(i_cfg_data);
                CFG_START_RULE:  r_cfg.start_rule  <= i_cfg_data;
                CFG_END_RULE:    r_cfg.end_rule    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    e2lc_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    e2lc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_epoch_seconds   (i_epoch_seconds),
        .o_valid           (o_valid),
        .o_second          (o_second),
        .o_minute          (o_minute),
        .o_hour            (o_hour),
        .o_month_day       (o_month_day),
        .o_month           (o_month),
        .o_year_since_1900 (o_year_since_1900),
        .o_year_day        (o_year_day),
        .o_week_day        (o_week_day),
        .o_is_dst          (o_is_dst)
    );

endmodule

/* rtl/e2lc_ctl.sv */
// ----------------------------------------------------------------------------
// e2lc_ctl
// Sequencer for the calendar converter: divisions, year and month walks,
// daylight rule evaluation and the optional second pass.
// ----------------------------------------------------------------------------
module e2lc_ctl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  e2lc_pkg::t_sts i_sts,
    output e2lc_pkg::t_cmd o_cmd
);
    import e2lc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.dsel = DSEL_DAY;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // clamp the local time of the first pass
                o_cmd.div_load = 1'b1;
                n_state = S_DDAY;
            end
            S_DDAY: begin
                o_cmd.div_step = 1'b1;
                o_cmd.dsel = DSEL_DAY;
                n_state = S_DDREM;
            end
            S_DDREM: begin
                o_cmd.div_step = 1'b1;
                o_cmd.dsel = DSEL_DREM;
                n_state = S_DHOUR;
            end
            S_DHOUR: begin
                o_cmd.div_step = 1'b1;
                o_cmd.dsel = DSEL_HOUR;
                n_state = S_DHREM;
            end
            S_DHREM: begin
                o_cmd.div_step = 1'b1;
                o_cmd.dsel = DSEL_HREM;
                n_state = S_DMIN;
            end
            S_DMIN: begin
                o_cmd.div_step = 1'b1;
                o_cmd.dsel = DSEL_MIN;
                n_state = S_DMREM;
            end
            S_DMREM: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.dsel      = DSEL_MREM;
                o_cmd.year_init = 1'b1;
                n_state = S_YEAR;
            end
            S_YEAR: begin
                if (i_sts.year_done) begin
                    o_cmd.mon_init = 1'b1;
                    n_state = S_MON;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MON: begin
                if (!i_sts.mon_done) begin
                    o_cmd.mon_step = 1'b1;
                end else if (i_sts.pass) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rule_init = 1'b1;
                    n_state = S_RSTART;
                end
            end
            S_RSTART: begin
                if (i_sts.rule_done) begin
                    o_cmd.rule_init = 1'b1;
                    o_cmd.rule_end  = 1'b1;
                    n_state = S_REND;
                end else begin
                    o_cmd.rule_step = 1'b1;
                end
            end
            S_REND: begin
                o_cmd.rule_end = 1'b1;
                if (!i_sts.rule_done) begin
                    o_cmd.rule_step = 1'b1;
                end else if (i_sts.dst) begin
                    // redo the breakdown with the daylight shift
                    o_cmd.div_load  = 1'b1;
                    o_cmd.add_shift = 1'b1;
                    o_cmd.dsel = DSEL_DAY;
                    n_state = S_DDAY;
                end else begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* rtl/e2lc_dp.sv */
// ----------------------------------------------------------------------------
// e2lc_dp
// Datapath: reciprocal-multiply division steps, year and month counters,
// rule day unit and result registers.
// ----------------------------------------------------------------------------
module e2lc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  e2lc_pkg::t_cfg       i_cfg,
    input  e2lc_pkg::t_cmd       i_cmd,
    output e2lc_pkg::t_sts       o_sts,
    input  logic signed [31:0]   i_epoch_seconds,
    output logic                 o_valid,
    output logic [5:0]           o_second,
    output logic [5:0]           o_minute,
    output logic [4:0]           o_hour,
    output logic [4:0]           o_month_day,
    output logic [3:0]           o_month,
    output logic [7:0]           o_year_since_1900,
    output logic [8:0]           o_year_day,
    output logic [2:0]           o_week_day,
    output logic                 o_is_dst
);
    import e2lc_pkg::*;

    logic signed [33:0] r_t;
    logic               r_pass;
    logic [31:0]        r_x;
    logic [16:0]        r_rem;
    logic [14:0]        r_wq;
    logic [16:0]        r_days;
    logic [4:0]         r_hr;
    logic [5:0]         r_min;
    logic [5:0]         r_sec;
    logic [2:0]         r_wday;
    logic [11:0]        r_year;
    logic [1:0]         r_m4;
    logic [6:0]         r_m100;
    logic [8:0]         r_m400;
    logic [11:0]        r_m4000;
    logic [8:0]         r_yday;
    logic [3:0]         r_mon;
    logic signed [7:0]  r_rd;
    logic signed [7:0]  r_xs;
    logic signed [3:0]  r_rn;
    logic               r_norm;

    logic signed [33:0] t_loc;
    logic [31:0]        x_clamp;
    logic [50:0]        day_prod;
    logic [33:0]        day_back;
    logic [16:0]        d4;
    logic [34:0]        wk_prod;
    logic [17:0]        wk_back;
    logic [26:0]        hr_prod;
    logic [17:0]        hr_back;
    logic [20:0]        mn_prod;
    logic [17:0]        mn_back;
    logic               leap;
    logic [8:0]         ylen;
    logic [4:0]         mlen;
    logic [17:0]        rule;
    logic signed [3:0]  nth;
    logic [4:0]         rday;
    logic signed [7:0]  d_init;
    logic signed [7:0]  len_s;
    logic signed [7:0]  mday_s;
    logic [4:0]         mday;
    logic [3:0]         smon, emon;
    logic [4:0]         shr, ehr;
    logic               dst;

    always_comb begin
        t_loc   = r_t + (i_cmd.add_shift ? 34'(i_cfg.dst_shift) : 34'sd0);
        x_clamp = t_loc[33] ? 32'd0 : t_loc[31:0];
    end

    always_comb begin
        day_prod = 51'(r_x[31:7]) * 51'(DAY_RECIP);
        day_back = 34'(r_days) * 34'(SEC_PER_DAY);
        d4       = r_days + 17'(EPOCH_WDAY);
        wk_prod  = 35'(d4) * 35'(WEEK_RECIP);
        wk_back  = 18'(r_wq) * DAYS_PER_WEEK;
        hr_prod  = 27'(r_rem[16:4]) * 27'(HOUR_RECIP);
        hr_back  = 18'(r_hr) * SEC_PER_HOUR;
        mn_prod  = 21'(r_rem[11:2]) * 21'(MIN_RECIP);
        mn_back  = 18'(r_min) * SEC_PER_MIN;
    end

    always_comb begin
        leap = (r_m4000 != 12'd0) && ((r_m400 == 9'd0) || ((r_m100 != 7'd0) && (r_m4 == 2'd0)));
        ylen = leap ? 9'd366 : 9'd365;
        mlen = month_len(r_mon, leap);
        mday = r_days[4:0] + 5'd1;
    end

    always_comb begin
        rule   = i_cmd.rule_end ? i_cfg.end_rule : i_cfg.start_rule;
        nth    = $signed(rule[3:0]);
        rday   = rule[8:4];
        mday_s = $signed({3'b000, mday});
        d_init = mday_s - $signed({5'b00000, r_wday}) + $signed({3'b000, rday});
        len_s  = $signed({3'b000, mlen});
    end

    always_comb begin
        smon = i_cfg.start_rule[12:9];
        emon = i_cfg.end_rule[12:9];
        shr  = i_cfg.start_rule[17:13];
        ehr  = i_cfg.end_rule[17:13];
        if (!i_cfg.dst_enable) begin
            dst = 1'b0;
        end else if ((smon <= emon && (r_mon < smon || r_mon > emon)) ||
                     (smon > emon && r_mon < smon && r_mon > emon)) begin
            dst = 1'b0;
        end else if (r_mon == smon) begin
            dst = (mday_s != r_xs) ? (mday_s > r_xs) : (r_hr >= shr);
        end else if (r_mon == emon) begin
            dst = (mday_s != r_rd) ? (mday_s < r_rd) : ({1'b0, r_hr} + 6'd1 < {1'b0, ehr});
        end else begin
            dst = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_t <= 34'(i_epoch_seconds) - 34'(i_cfg.zone_offset);
        end
        if (i_cmd.div_load) begin
            r_x <= x_clamp;
        end
        if (i_cmd.div_step) begin
            case (i_cmd.dsel)
                DSEL_DAY: begin
                    r_days <= {1'b0, day_prod[50:35]};
                end
                DSEL_DREM: begin
                    r_rem <= r_x[16:0] - day_back[16:0];
                    r_wq  <= wk_prod[34:20];
                end
                DSEL_HOUR: begin
                    r_hr   <= hr_prod[25:21];
                    r_wday <= d4[2:0] - wk_back[2:0];
                end
                DSEL_HREM: begin
                    r_rem <= r_rem - hr_back[16:0];
                end
                DSEL_MIN: begin
                    r_min <= mn_prod[19:14];
                end
                default: begin
                    r_sec <= r_rem[5:0] - mn_back[5:0];
                end
            endcase
        end
        if (i_cmd.year_init) begin
            r_year  <= EPOCH_YEAR;
            r_m4    <= 2'd2;
            r_m100  <= 7'd70;
            r_m400  <= 9'd370;
            r_m4000 <= 12'd1970;
        end
        if (i_cmd.year_step) begin
            r_days  <= r_days - 17'(ylen);
            r_year  <= r_year + 12'd1;
            r_m4    <= r_m4 + 2'd1;
            r_m100  <= (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
            r_m400  <= (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
            r_m4000 <= (r_m4000 == 12'd3999) ? 12'd0 : r_m4000 + 12'd1;
        end
        if (i_cmd.mon_init) begin
            r_yday <= r_days[8:0];
            r_mon  <= 4'd0;
        end
        if (i_cmd.mon_step) begin
            r_days <= r_days - 17'(mlen);
            r_mon  <= r_mon + 4'd1;
        end
        if (i_cmd.rule_init) begin
            if (i_cmd.rule_end) begin
                r_xs <= r_rd;
            end
            r_rd   <= (nth == 4'sd0) ? $signed({3'b000, rday}) : d_init;
            r_rn   <= nth;
            r_norm <= (nth == 4'sd0);
        end else if (i_cmd.rule_step) begin
            if (!r_norm) begin
                // bring the day just before (or past) the month edge
                if (r_rn > 4'sd0) begin
                    if (r_rd > 8'sd0) r_rd <= r_rd - 8'sd7;
                    else              r_norm <= 1'b1;
                end else begin
                    if (r_rd <= len_s) r_rd <= r_rd + 8'sd7;
                    else               r_norm <= 1'b1;
                end
            end else if (r_rn > 4'sd0) begin
                r_rd <= r_rd + 8'sd7;
                r_rn <= r_rn - 4'sd1;
            end else begin
                r_rd <= r_rd - 8'sd7;
                r_rn <= r_rn + 4'sd1;
            end
        end
        if (i_cmd.out_load) begin
            o_second          <= r_sec;
            o_minute          <= r_min;
            o_hour            <= r_hr;
            o_month_day       <= mday;
            o_month           <= r_mon;
            o_year_since_1900 <= 8'(r_year - YEAR_BASE);
            o_year_day        <= r_yday;
            o_week_day        <= r_wday;
            o_is_dst          <= r_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            o_valid <= i_cmd.out_load;
            if (i_cmd.load_in) begin
                r_pass <= 1'b0;
            end else if (i_cmd.div_load) begin
                r_pass <= i_cmd.add_shift;
            end
        end
    end

    assign o_sts.year_done = (r_days < 17'(ylen));
    assign o_sts.mon_done  = (r_days < 17'(mlen));
    assign o_sts.rule_done = r_norm && (r_rn == 4'sd0);
    assign o_sts.dst       = dst;
    assign o_sts.pass      = r_pass;

endmodule
